FILE: hdl/mcsm_pkg.sv
package mcsm_pkg;

  // Action codes carried in the input tuser.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned VSEL_W   = 2;
  localparam int unsigned MASK_W   = 4;

  localparam logic [LEN_W-1:0] MAX_LEN = 13'd4096;
  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -127;

  // One entry of the voice table memory.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] position;
    logic              looping;
  } voice_entry_t;

  // Result of advancing one voice by one tick.
  typedef struct packed {
    voice_entry_t entry;
    logic         playing;
  } voice_upd_t;

endpackage

FILE: hdl/mcsm_voice_step.sv
module mcsm_voice_step #(
  parameter int unsigned AW = 12
) (
  input  mcsm_pkg::voice_entry_t entry_i,
  input  logic                   playing_i,
  output logic [AW-1:0]          rd_addr_o,
  output mcsm_pkg::voice_upd_t   upd_o
);
  import mcsm_pkg::*;

  localparam int unsigned XW = (AW > LEN_W) ? AW : LEN_W;

  logic [XW-1:0]    addr_sum;
  logic [LEN_W-1:0] pos_inc;

  // Playback address wraps at the memory depth, a power of two.
  assign addr_sum  = XW'(entry_i.base) + XW'(entry_i.position);
  assign rd_addr_o = addr_sum[AW-1:0];
  assign pos_inc   = LEN_W'(entry_i.position) + LEN_W'(1);

  always_comb begin
    upd_o         = '0;
    upd_o.entry   = entry_i;
    upd_o.playing = playing_i;
    if (playing_i) begin
      upd_o.entry.position = pos_inc[ADDR_W-1:0];
      if (pos_inc >= entry_i.length) begin
        if (entry_i.looping) begin
          upd_o.entry.position = ADDR_W'(pos_inc - entry_i.length);
        end else begin
          upd_o.playing = 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/multichannel_sample_mixer.sv
// Multichannel sample mixer: several voices play signed 8-bit samples from a
// shared sample memory and are summed into one saturated output sample.
// Input items arrive on the s_axis channel; tuser selects the action: tick,
// load one sample byte, start a voice or stop a voice. Load, start and stop
// take effect at the edge that accepts them and produce no result, so they
// run at one item per cycle while no tick is in progress. A tick produces
// exactly one result item on the m_axis channel, carrying the saturated
// sum, a clip flag and the mask of voices still playing afterwards.
// A tick walks the voice table memory one voice per cycle, then reads the
// sample memory and accumulates, two pipeline stages behind the table read.
// The result is registered once the last voice has been accumulated, and
// the block takes its next item only once that result register is loaded;
// the walk goes one voice at a time because of the single table read port.
// The output register decouples the sides: new items are accepted while a
// result waits, and only a tick finishing into a still-full output register
// holds until the receiver takes the earlier result.
// Reset stops all voices and empties the output register; the sample memory
// keeps no reset value and must be loaded before any voice plays from it.
// SAMPLE_MEM_DEPTH must be a power of two.
module multichannel_sample_mixer #(
  parameter int unsigned VOICES           = 4,
  parameter int unsigned SAMPLE_MEM_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // voice[1:0], address[13:2], sample_byte[21:14], sample_count[34:22],
  // loop_flag[35], stream_on[36], stream_sample[44:37], zero fill above
  input  logic [47:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mixed_sample[7:0], playing_mask[11:8], zero fill above
  output logic [15:0] m_axis_tdata,
  // clipped
  output logic        m_axis_tuser
);
  import mcsm_pkg::*;

  localparam int unsigned AW    = $clog2(SAMPLE_MEM_DEPTH);
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW    = $clog2(VOICES + 1);
  // One bit above both the selector and the voice index, so VOICES fits.
  localparam int unsigned IW    = ((VW > VSEL_W) ? VW : VSEL_W) + 1;
  localparam int unsigned LW    = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int unsigned ACC_W = SAMPLE_W + 1 + $clog2(VOICES + 1);
  localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] NEG_LIM = ACC_W'(SAT_MIN);

  // Input field unpacking.
  act_e                        in_act;
  logic [VSEL_W-1:0]           in_voice;
  logic [ADDR_W-1:0]           in_addr;
  logic signed [SAMPLE_W-1:0]  in_byte;
  logic [LEN_W-1:0]            in_count;
  logic                        in_loop;
  logic                        in_stream_on;
  logic signed [SAMPLE_W-1:0]  in_stream;

  assign in_act       = act_e'(s_axis_tuser);
  assign in_voice     = s_axis_tdata[1:0];
  assign in_addr      = s_axis_tdata[13:2];
  assign in_byte      = s_axis_tdata[21:14];
  assign in_count     = s_axis_tdata[34:22];
  assign in_loop      = s_axis_tdata[35];
  assign in_stream_on = s_axis_tdata[36];
  assign in_stream    = s_axis_tdata[44:37];

  state_e state_q, state_d;

  logic                    accept;
  logic [IW-1:0]           voice_ext;
  logic                    voice_ok;
  logic [VW-1:0]           voice_idx;
  logic [LW-1:0]           load_addr_ext;
  logic [LEN_W-1:0]        start_len;

  // Memories.
  logic [SAMPLE_W-1:0]     smem [SAMPLE_MEM_DEPTH];
  voice_entry_t            vt_mem [VOICES];
  logic signed [SAMPLE_W-1:0] smem_rd_q;
  voice_entry_t            vt_rd_q;

  // Voice walk and pipeline.
  logic [CW-1:0]           rd_cnt_q, rd_cnt_d;
  logic                    rd_en;
  logic                    s1_q, s1_last_q;
  logic [VW-1:0]           s1_idx_q;
  logic                    s2_q, s2_play_q, s2_last_q;
  logic [VOICES-1:0]       play_q, play_d;
  logic [MASK_W-1:0]       mask_q, mask_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic [AW-1:0]           step_addr;
  voice_upd_t              step_upd;

  logic                    vt_we;
  logic [VW-1:0]           vt_waddr;
  voice_entry_t            vt_wdata;

  // Output register.
  logic                    out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                    out_clip_q;
  logic [MASK_W-1:0]       out_mask_q;
  logic                    out_free;
  logic                    out_load;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic                    sat_clip;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign voice_ext     = IW'(in_voice);
  assign voice_ok      = voice_ext < IW'(VOICES);
  assign voice_idx     = voice_ext[VW-1:0];
  assign load_addr_ext = LW'(in_addr);
  assign start_len     = (in_count > MAX_LEN) ? MAX_LEN : in_count;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_act == ACT_TICK) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s2_q && s2_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RUN:  rd_en         = rd_cnt_q < CW'(VOICES);
      ST_DONE: out_load      = out_free;
      default: s_axis_tready = 1'b0;
    endcase
  end

  mcsm_voice_step #(
    .AW(AW)
  ) u_step (
    .entry_i  (vt_rd_q),
    .playing_i(play_q[s1_idx_q]),
    .rd_addr_o(step_addr),
    .upd_o    (step_upd)
  );

  // Voice table write port: a start command in idle, or the write-back of
  // the voice in stage one during a tick. The two never coincide.
  always_comb begin
    vt_we    = 1'b0;
    vt_waddr = s1_idx_q;
    vt_wdata = step_upd.entry;
    if (s1_q) begin
      vt_we = 1'b1;
    end else if (accept && in_act == ACT_START && voice_ok) begin
      vt_we             = 1'b1;
      vt_waddr          = voice_idx;
      vt_wdata.base     = in_addr;
      vt_wdata.length   = start_len;
      vt_wdata.position = '0;
      vt_wdata.looping  = in_loop;
    end
  end

  // Playing bits, mask, counter and accumulator.
  always_comb begin
    play_d   = play_q;
    mask_d   = mask_q;
    rd_cnt_d = rd_cnt_q;
    acc_d    = acc_q;
    if (accept) begin
      unique case (in_act)
        ACT_START: begin
          if (voice_ok) begin
            play_d[voice_idx] = start_len != '0;
          end
        end
        ACT_STOP: begin
          if (voice_ok) begin
            play_d[voice_idx] = 1'b0;
          end
        end
        ACT_TICK: begin
          mask_d   = '0;
          rd_cnt_d = '0;
          acc_d    = in_stream_on ? ACC_W'(in_stream) : '0;
        end
        ACT_LOAD: begin
          play_d = play_q;
        end
        default: play_d = play_q;
      endcase
    end
    if (rd_en) begin
      rd_cnt_d = rd_cnt_q + CW'(1);
    end
    if (s1_q) begin
      play_d[s1_idx_q] = step_upd.playing;
      for (int k = 0; k < MASK_W; k++) begin
        if (k < VOICES && IW'(s1_idx_q) == IW'(k)) begin
          mask_d[k] = step_upd.playing;
        end
      end
    end
    if (s2_q && s2_play_q) begin
      acc_d = acc_q + ACC_W'(smem_rd_q);
    end
  end

  // Saturation of the finished sum.
  always_comb begin
    sat_sample = acc_q[SAMPLE_W-1:0];
    sat_clip   = 1'b0;
    if (acc_q > POS_LIM) begin
      sat_sample = SAMPLE_W'(SAT_MAX);
      sat_clip   = 1'b1;
    end else if (acc_q < NEG_LIM) begin
      sat_sample = SAMPLE_W'(SAT_MIN);
      sat_clip   = 1'b1;
    end
  end

  // Sample memory: write on load, read for the voice in stage one.
  always_ff @(posedge clk_i) begin
    if (accept && in_act == ACT_LOAD) begin
      smem[load_addr_ext[AW-1:0]] <= in_byte;
    end
    smem_rd_q <= smem[step_addr];
  end

  // Voice table memory.
  always_ff @(posedge clk_i) begin
    if (vt_we) begin
      vt_mem[vt_waddr] <= vt_wdata;
    end
    vt_rd_q <= vt_mem[rd_cnt_q[VW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      s1_q        <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_idx_q    <= '0;
      s2_q        <= 1'b0;
      s2_play_q   <= 1'b0;
      s2_last_q   <= 1'b0;
      play_q      <= '0;
      mask_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      s1_q      <= rd_en;
      s1_last_q <= rd_cnt_q == CW'(VOICES - 1);
      s1_idx_q  <= rd_cnt_q[VW-1:0];
      s2_q      <= s1_q;
      s2_play_q <= s1_q && play_q[s1_idx_q];
      s2_last_q <= s1_q && s1_last_q;
      play_q    <= play_d;
      mask_q    <= mask_d;
      acc_q     <= acc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= sat_sample;
      out_clip_q   <= sat_clip;
      out_mask_q   <= mask_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_mask_q, out_sample_q};
  assign m_axis_tuser  = out_clip_q;

`ifndef ASSERT_OFF
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_sample_q != 8'sh80)
    else $error("mixer emitted -128");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |->
      (out_sample_q == 8'sh7f || out_sample_q == 8'sh81))
    else $error("clip flag set on an unsaturated sample");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q |-> $past(s1_q))
    else $error("stage two ran without stage one");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_DONE && !s1_q && !s2_q)
    else $error("result loaded while voices still in flight");
`endif

endmodule

FILE: tb/mix_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the mixer, keeps its own copy of the voice table
// and sample memory, and compares every result item against the oldest
// predicted mix.
module mix_checker #(
  parameter int VOICES           = 4,
  parameter int SAMPLE_MEM_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // voice, address, sample_byte, sample_count, loop_flag, stream_on,
  // stream_sample, zero fill
  input  logic [47:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mixed_sample, playing_mask, zero fill
  input  logic [15:0] m_axis_tdata,
  // clipped
  input  logic        m_axis_tuser,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          clips_o
);
  import mcsm_pkg::*;

  typedef struct packed {
    logic [2:0]          fill;
    logic [SAMPLE_W-1:0] stream_sample;
    logic                stream_on;
    logic                loop_flag;
    logic [LEN_W-1:0]    sample_count;
    logic [SAMPLE_W-1:0] sample_byte;
    logic [ADDR_W-1:0]   address;
    logic [VSEL_W-1:0]   voice;
  } mix_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mixed;
    logic                clipped;
    logic [MASK_W-1:0]   mask;
  } mix_result_t;

  logic [SAMPLE_W-1:0] sample_mem [SAMPLE_MEM_DEPTH];
  logic [ADDR_W-1:0]   voice_base [VOICES];
  logic [LEN_W-1:0]    voice_len  [VOICES];
  // One bit wider than an address, since a full-length voice counts to 4096.
  logic [LEN_W-1:0]    voice_pos  [VOICES];
  logic                voice_play [VOICES];
  logic                voice_loop [VOICES];

  mix_result_t expected_mix [$];
  int mismatch_count = 0;
  int result_count   = 0;
  int clip_count     = 0;

  assign errors_o  = mismatch_count;
  assign results_o = result_count;
  assign clips_o   = clip_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic predict_item(input act_e act, input mix_item_t it);
    int          sum;
    int          rd_idx;
    logic [MASK_W-1:0] mask;
    mix_result_t res;
    sum  = 0;
    mask = '0;
    case (act)
      ACT_LOAD: begin
        sample_mem[int'(it.address) % SAMPLE_MEM_DEPTH] = it.sample_byte;
      end
      ACT_START: begin
        if (int'(it.voice) < VOICES) begin
          voice_base[it.voice] = it.address;
          voice_len[it.voice]  = (it.sample_count > MAX_LEN) ? MAX_LEN : it.sample_count;
          voice_loop[it.voice] = it.loop_flag;
          voice_pos[it.voice]  = '0;
          voice_play[it.voice] = (it.sample_count != '0);
        end
      end
      ACT_STOP: begin
        if (int'(it.voice) < VOICES) voice_play[it.voice] = 1'b0;
      end
      default: begin
        for (int v = 0; v < VOICES; v++) begin
          if (voice_play[v]) begin
            rd_idx = (int'(voice_base[v]) + int'(voice_pos[v])) % SAMPLE_MEM_DEPTH;
            sum += $signed(sample_mem[rd_idx]);
            voice_pos[v] = voice_pos[v] + 1'b1;
            if (voice_pos[v] >= voice_len[v]) begin
              if (voice_loop[v]) voice_pos[v] = voice_pos[v] - voice_len[v];
              else voice_play[v] = 1'b0;
            end
            if (voice_play[v] && v < MASK_W) mask[v] = 1'b1;
          end
        end
        if (it.stream_on) sum += $signed(it.stream_sample);
        res.clipped = 1'b0;
        if (sum > SAT_MAX) begin
          sum = SAT_MAX;
          res.clipped = 1'b1;
        end
        if (sum < SAT_MIN) begin
          sum = SAT_MIN;
          res.clipped = 1'b1;
        end
        res.mixed = sum[SAMPLE_W-1:0];
        res.mask  = mask;
        expected_mix.push_back(res);
      end
    endcase
  endtask

  task automatic check_result();
    mix_result_t want;
    result_count++;
    if (expected_mix.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no tick waiting", result_count));
      return;
    end
    want = expected_mix.pop_front();
    if (want.clipped) clip_count++;
    if (m_axis_tdata[7:0] !== want.mixed)
      report_mismatch($sformatf("result %0d mixed_sample got %0d want %0d", result_count,
                                $signed(m_axis_tdata[7:0]), $signed(want.mixed)));
    if (m_axis_tdata[11:8] !== want.mask)
      report_mismatch($sformatf("result %0d playing_mask got %b want %b", result_count,
                                m_axis_tdata[11:8], want.mask));
    if (m_axis_tuser !== want.clipped)
      report_mismatch($sformatf("result %0d clipped got %b want %b", result_count,
                                m_axis_tuser, want.clipped));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        voice_base[v] = '0;
        voice_len[v]  = '0;
        voice_pos[v]  = '0;
        voice_play[v] = 1'b0;
        voice_loop[v] = 1'b0;
      end
      expected_mix.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        predict_item(act_e'(s_axis_tuser), mix_item_t'(s_axis_tdata));
      pending_o <= expected_mix.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the sample mixer. A checker beside the block
// predicts and compares; this module only generates items, drives the
// receiver's ready and decides pass or fail.
module tb_top;
  import mcsm_pkg::*;

  localparam int VOICES         = 4;
  localparam int DEPTH          = 4096;
  localparam int PHASES         = 10;
  // Items accepted per phase, the loads placed ahead of ticks included.
  localparam int PHASE_ITEMS    = 125;
  localparam int DRAIN_CYCLES   = 20;
  // Far above the slowest legal run: roughly 1300 items, even if every one
  // were a tick, stretched by long random stalls.
  localparam int CYCLE_LIMIT    = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // voice[1:0], address[13:2], sample_byte[21:14], sample_count[34:22],
  // loop_flag[35], stream_on[36], stream_sample[44:37], zero fill above
  logic [47:0] s_axis_tdata  = '0;
  // action[1:0]
  logic [1:0]  s_axis_tuser  = ACT_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // mixed_sample[7:0], playing_mask[11:8], zero fill above
  logic [15:0] m_axis_tdata;
  // clipped
  logic        m_axis_tuser;

  int errors;
  int pending;
  int results;
  int clips;

  int cycle_count     = 0;
  int items_sent      = 0;
  int phase_end       = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // The stimulus keeps a rough plan of each voice so that it knows which
  // sample memory entry the next tick will read. An entry that was never
  // loaded is loaded just before the tick that would read it.
  bit                mem_loaded [DEPTH];
  bit [ADDR_W-1:0]   plan_base  [VOICES];
  bit [LEN_W-1:0]    plan_len   [VOICES];
  bit [LEN_W-1:0]    plan_pos   [VOICES];
  bit                plan_play  [VOICES];
  bit                plan_loop  [VOICES];

  multichannel_sample_mixer #(
    .VOICES          (VOICES),
    .SAMPLE_MEM_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  mix_checker #(
    .VOICES          (VOICES),
    .SAMPLE_MEM_DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results),
    .clips_o      (clips)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [47:0] pack_item(input logic [1:0] v, input logic [11:0] a,
                                            input logic [7:0] b, input logic [12:0] n,
                                            input logic lp, input logic so,
                                            input logic [7:0] ss);
    return {3'b000, ss, so, lp, n, b, a, v};
  endfunction

  // Half the bytes are small so that sums of several voices often stay in
  // range; the other half span the full signed range and clip readily.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1) == 1) return 8'($urandom_range(255));
    return 8'(int'($urandom_range(80)) - 40);
  endfunction

  // Mostly short lengths so that voices end and loop often; now and then a
  // zero, the full memory or an oversize count that the block must clamp.
  function automatic logic [12:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 13'($urandom_range(24, 1));
    if (r < 84) return 13'($urandom_range(300, 25));
    if (r < 89) return 13'd0;
    if (r < 94) return MAX_LEN;
    return 13'($urandom_range(8191, 4097));
  endfunction

  // Bases near the top of memory make playback wrap around address zero.
  function automatic logic [11:0] pick_base();
    if ($urandom_range(99) < 20) return 12'($urandom_range(4095, 4080));
    return 12'($urandom_range(4095));
  endfunction

  // Presents one item, with an optional idle gap first, and returns once it
  // has been accepted. Valid stays high when the next item follows at once.
  task automatic drive_item(input act_e act, input logic [47:0] data);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Sends one command and keeps the voice plan in step with it. Before a
  // tick, every entry that a playing voice is about to read gets loaded if
  // it never was.
  task automatic issue(input act_e act, input logic [1:0] v, input logic [11:0] a,
                       input logic [7:0] b, input logic [12:0] n, input logic lp,
                       input logic so, input logic [7:0] ss);
    int rd;
    if (act == ACT_TICK) begin
      for (int i = 0; i < VOICES; i++) begin
        rd = (int'(plan_base[i]) + int'(plan_pos[i])) % DEPTH;
        if (plan_play[i] && !mem_loaded[rd]) begin
          drive_item(ACT_LOAD, pack_item(2'($urandom_range(3)), 12'(rd), pick_byte(),
                                         13'($urandom_range(8191)), 1'($urandom_range(1)),
                                         1'($urandom_range(1)), 8'($urandom_range(255))));
          mem_loaded[rd] = 1'b1;
        end
      end
    end
    drive_item(act, pack_item(v, a, b, n, lp, so, ss));
    case (act)
      ACT_LOAD: begin
        mem_loaded[int'(a) % DEPTH] = 1'b1;
      end
      ACT_START: begin
        plan_base[v] = a;
        plan_len[v]  = (n > MAX_LEN) ? MAX_LEN : n;
        plan_pos[v]  = '0;
        plan_loop[v] = lp;
        plan_play[v] = (n != '0);
      end
      ACT_STOP: begin
        plan_play[v] = 1'b0;
      end
      default: begin
        for (int i = 0; i < VOICES; i++) begin
          if (plan_play[i]) begin
            plan_pos[i] = plan_pos[i] + 1'b1;
            if (plan_pos[i] >= plan_len[i]) begin
              if (plan_loop[i]) plan_pos[i] = plan_pos[i] - plan_len[i];
              else plan_play[i] = 1'b0;
            end
          end
        end
      end
    endcase
  endtask

  // One random command. Every field carries random content, including the
  // ones that the chosen action does not use.
  task automatic random_item();
    logic [1:0]  v;
    logic [11:0] a;
    logic [12:0] n;
    logic [7:0]  b;
    logic [7:0]  ss;
    logic        lp;
    logic        so;
    int          r;
    v  = 2'($urandom_range(3));
    a  = pick_base();
    n  = pick_length();
    b  = pick_byte();
    ss = 8'($urandom_range(255));
    lp = 1'($urandom_range(1));
    so = 1'($urandom_range(1));
    r  = $urandom_range(99);
    if (r < 45) issue(ACT_TICK, v, a, b, n, lp, so, ss);
    else if (r < 70) issue(ACT_LOAD, v, a, b, n, lp, so, ss);
    else if (r < 88) issue(ACT_START, v, a, b, n, lp, so, ss);
    else issue(ACT_STOP, v, a, b, n, lp, so, ss);
  endtask

  // Holds the sender off until every predicted result has arrived. The
  // first edge lets the checker count the item accepted just before.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with no idling on either side.
    // With nothing playing the sum is just the stream, or zero without it.
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // A stream of -128 alone is the minimum sum and must clip to -127.
    issue(ACT_TICK, 2'd3, 12'hFFF, 8'hFF, 13'h1FFF, 1'b1, 1'b1, 8'h80);
    // The top of the range passes without clipping.
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b1, 8'h7F);
    issue(ACT_LOAD, 2'd0, 12'h000, 8'h80, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_LOAD, 2'd0, 12'hFFF, 8'h7F, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_LOAD, 2'd0, 12'h001, 8'h7F, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_LOAD, 2'd0, 12'h002, 8'h81, 13'd0, 1'b0, 1'b0, 8'h00);
    // A one-sample voice plays -128 once and stops at its end.
    issue(ACT_START, 2'd0, 12'h000, 8'h00, 13'd1, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // A looping voice at the last address wraps through address zero.
    issue(ACT_START, 2'd1, 12'hFFF, 8'h00, 13'd2, 1'b1, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // A zero length leaves the voice stopped.
    issue(ACT_START, 2'd2, 12'h001, 8'h00, 13'd0, 1'b1, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // The largest count is clamped to the full memory.
    issue(ACT_START, 2'd3, 12'h001, 8'h00, 13'h1FFF, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // A restart of a playing voice begins again at its new base.
    issue(ACT_START, 2'd0, 12'h000, 8'h00, MAX_LEN, 1'b1, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_START, 2'd3, 12'h002, 8'h00, 13'd3, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    // Stops, one of them on a voice that is not playing.
    issue(ACT_STOP, 2'd1, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_STOP, 2'd2, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b1, 8'h7F);
    issue(ACT_STOP, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_STOP, 2'd3, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);
    issue(ACT_TICK, 2'd0, 12'h000, 8'h00, 13'd0, 1'b0, 1'b0, 8'h00);

    // Random part in phases that cycle through the idle patterns. Each phase
    // starts only once every predicted result has come back.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 55;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 55;
        end
        default: begin
          sender_idle_pct = 12;
          stall_pct       = 12;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_item();
    end

    // Let the last results drain, then give the block a few idle cycles.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d items accepted, %0d mixed results checked, %0d of them saturated.",
             items_sent, results, clips);
    $display("Summary: loads, starts of every length class, restarts, stops and looping %s",
             "were run under four idle patterns.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mcsm_pkg.sv
hdl/mcsm_voice_step.sv
hdl/multichannel_sample_mixer.sv
tb/mix_checker.sv
tb/tb_top.sv
